/* sv/tcgelf_pkg.sv */
// Shared types, codes and constants for the event log framer.
package tcgelf_pkg;

    localparam int ENTRY_COUNT_BITS_DEF = 16;

    localparam logic [31:0] NO_ACTION_TYPE_RST = 32'd3;
    localparam logic [3:0]  MAX_DIGESTS_RST    = 4'd8;

    localparam int HDR_DIGEST_BYTES = 20;

    localparam logic [15:0] ALG_SHA1   = 16'h0004;
    localparam logic [15:0] ALG_SHA256 = 16'h000B;
    localparam logic [15:0] ALG_SHA384 = 16'h000C;
    localparam logic [15:0] ALG_SHA512 = 16'h000D;
    localparam logic [15:0] ALG_SM3    = 16'h0012;

    localparam logic [2:0] BANK_SHA1   = 3'd0;
    localparam logic [2:0] BANK_SHA256 = 3'd1;
    localparam logic [2:0] BANK_SHA384 = 3'd2;
    localparam logic [2:0] BANK_SHA512 = 3'd3;
    localparam logic [2:0] BANK_SM3    = 3'd4;

    localparam logic [3:0] ROLE_HEADER  = 4'd0;
    localparam logic [3:0] ROLE_INDEX   = 4'd1;
    localparam logic [3:0] ROLE_TYPE    = 4'd2;
    localparam logic [3:0] ROLE_COUNT   = 4'd3;
    localparam logic [3:0] ROLE_ALG     = 4'd4;
    localparam logic [3:0] ROLE_DIGEST  = 4'd5;
    localparam logic [3:0] ROLE_SIZE    = 4'd6;
    localparam logic [3:0] ROLE_DATA    = 4'd7;
    localparam logic [3:0] ROLE_IGNORED = 4'd8;

    localparam logic [1:0] STOP_NONE      = 2'd0;
    localparam logic [1:0] STOP_TRUNCATED = 2'd1;
    localparam logic [1:0] STOP_TOO_MANY  = 2'd2;
    localparam logic [1:0] STOP_BAD_ALG   = 2'd3;

    localparam logic REG_NO_ACTION_TYPE = 1'b0;
    localparam logic REG_MAX_DIGESTS    = 1'b1;

    typedef enum logic [10:0] {
        PH_INDEX      = 11'b000_0000_0001,
        PH_TYPE       = 11'b000_0000_0010,
        PH_HDR_DIGEST = 11'b000_0000_0100,
        PH_HDR_SIZE   = 11'b000_0000_1000,
        PH_HDR_DATA   = 11'b000_0001_0000,
        PH_COUNT      = 11'b000_0010_0000,
        PH_ALG        = 11'b000_0100_0000,
        PH_DIGEST     = 11'b000_1000_0000,
        PH_SIZE       = 11'b001_0000_0000,
        PH_DATA       = 11'b010_0000_0000,
        PH_STOP       = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] bank;
    } bank_hit_t;

    function automatic bank_hit_t bank_lookup(input logic [15:0] alg);
        bank_hit_t hit;
        hit.valid = 1'b1;
        hit.bank  = BANK_SHA1;
        unique case (alg)
            ALG_SHA1:   hit.bank = BANK_SHA1;
            ALG_SHA256: hit.bank = BANK_SHA256;
            ALG_SHA384: hit.bank = BANK_SHA384;
            ALG_SHA512: hit.bank = BANK_SHA512;
            ALG_SM3:    hit.bank = BANK_SM3;
            default:    hit.valid = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [6:0] bank_size(input logic [2:0] bank);
        logic [6:0] sz;
        unique case (bank)
            BANK_SHA1:   sz = 7'd20;
            BANK_SHA256: sz = 7'd32;
            BANK_SHA384: sz = 7'd48;
            BANK_SHA512: sz = 7'd64;
            BANK_SM3:    sz = 7'd32;
            default:     sz = 7'd20;
        endcase
        return sz;
    endfunction

endpackage

/* sv/tcg_event_log_framer_core.sv */
// Event log framer: byte-wise record parser with registered two-entry result buffer.
// Takes one log byte per beat and returns one result beat per byte, in order. A byte
// can be accepted on every clock while the skid entry is empty; its result goes to the
// output register, or to the skid entry while the master side stalls, which keeps the
// slave side open for one more beat. The per-byte parse step is one state update
// per accepted byte, so the rate is one byte per cycle while m_tready is high.
// Configuration must be written through the APB port while idle; it is not enforced.
module tcg_event_log_framer_core
    import tcgelf_pkg::*;
#(
    parameter int ENTRY_COUNT_BITS = ENTRY_COUNT_BITS_DEF,
    localparam int DATA_BITS = 111 + ENTRY_COUNT_BITS,
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // log_byte
    input  logic                  s_tlast,   // last

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // digest_bank, entry_done, pcr_index, event_type, digest_count, bank_mask,
    // data_length, stop_status, entry_count, zero fill
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [3:0]            m_tuser,   // byte_role
    output logic                  m_tlast    // log_done
);

    typedef struct packed {
        logic [3:0]                  byte_role;
        logic                        log_done;
        logic [ENTRY_COUNT_BITS-1:0] entry_count;
        logic [1:0]                  stop_status;
        logic [31:0]                 data_length;
        logic [4:0]                  bank_mask;
        logic [3:0]                  digest_count;
        logic [31:0]                 event_type;
        logic [31:0]                 pcr_index;
        logic                        entry_done;
        logic [2:0]                  digest_bank;
    } result_t;

    // configuration
    logic [31:0] no_action_reg;
    logic [3:0]  max_digests_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_action_reg   <= NO_ACTION_TYPE_RST;
            max_digests_reg <= MAX_DIGESTS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NO_ACTION_TYPE) begin
                no_action_reg <= pwdata;
            end else begin
                max_digests_reg <= pwdata[3:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_NO_ACTION_TYPE) begin
            prdata = no_action_reg;
        end else begin
            prdata = {28'd0, max_digests_reg};
        end
    end

    // parser state
    phase_t                      phase_reg,     phase_next;
    logic                        first_reg,     first_next;
    logic [6:0]                  cnt_reg,       cnt_next;
    logic [31:0]                 fa_reg,        fa_next;
    logic [31:0]                 index_reg,     index_next;
    logic [31:0]                 type_reg,      type_next;
    logic [3:0]                  dtotal_reg,    dtotal_next;
    logic [3:0]                  dleft_reg,     dleft_next;
    logic [2:0]                  bank_reg,      bank_next;
    logic [4:0]                  seen_reg,      seen_next;
    logic [31:0]                 dlen_reg,      dlen_next;
    logic [1:0]                  stop_reg,      stop_next;
    logic [ENTRY_COUNT_BITS-1:0] records_reg,   records_next;

    logic        push, pop;
    logic [7:0]  cnt_inc;
    logic        take4_end, take2_end;
    logic [31:0] fa_base, fa_new;
    logic [3:0]  dleft_dec;
    logic        done, boundary;
    bank_hit_t   hit;
    result_t     res;

    assign cnt_inc   = {1'b0, cnt_reg} + 8'd1;
    assign take4_end = cnt_inc >= 8'd4;
    assign take2_end = cnt_inc >= 8'd2;
    assign fa_base   = (cnt_reg == 7'd0) ? 32'd0 : fa_reg;
    assign fa_new    = fa_base | ({24'd0, s_tdata} << {cnt_reg[1:0], 3'b000});
    assign dleft_dec = dleft_reg - 4'd1;
    assign hit       = bank_lookup(fa_new[15:0]);

    always_comb begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        cnt_next     = cnt_reg;
        fa_next      = fa_reg;
        index_next   = index_reg;
        type_next    = type_reg;
        dtotal_next  = dtotal_reg;
        dleft_next   = dleft_reg;
        bank_next    = bank_reg;
        seen_next    = seen_reg;
        dlen_next    = dlen_reg;
        stop_next    = stop_reg;
        records_next = records_reg;
        done         = 1'b0;
        boundary     = 1'b0;
        res          = '0;
        res.byte_role = ROLE_IGNORED;

        unique case (phase_reg)
            PH_INDEX: begin
                res.byte_role = ROLE_INDEX;
                fa_next  = fa_new;
                cnt_next = take4_end ? 7'd0 : cnt_inc[6:0];
                if (take4_end) begin
                    index_next = fa_new;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                res.byte_role = ROLE_TYPE;
                fa_next  = fa_new;
                cnt_next = take4_end ? 7'd0 : cnt_inc[6:0];
                if (take4_end) begin
                    type_next  = fa_new;
                    first_next = 1'b0;
                    phase_next = (first_reg && fa_new == no_action_reg) ? PH_HDR_DIGEST
                                                                        : PH_COUNT;
                end
            end
            PH_HDR_DIGEST: begin
                res.byte_role = ROLE_HEADER;
                if (cnt_inc >= 8'(HDR_DIGEST_BYTES)) begin
                    cnt_next   = 7'd0;
                    phase_next = PH_HDR_SIZE;
                end else begin
                    cnt_next = cnt_inc[6:0];
                end
            end
            PH_HDR_SIZE: begin
                res.byte_role = ROLE_HEADER;
                fa_next  = fa_new;
                cnt_next = take4_end ? 7'd0 : cnt_inc[6:0];
                if (take4_end) begin
                    dlen_next = fa_new;
                    if (fa_new == 32'd0) begin
                        phase_next = PH_INDEX;
                        boundary   = 1'b1;
                    end else begin
                        phase_next = PH_HDR_DATA;
                    end
                end
            end
            PH_HDR_DATA: begin
                res.byte_role = ROLE_HEADER;
                dlen_next = dlen_reg - 32'd1;
                if (dlen_next == 32'd0) begin
                    phase_next = PH_INDEX;
                    boundary   = 1'b1;
                end
            end
            PH_COUNT: begin
                res.byte_role = ROLE_COUNT;
                fa_next  = fa_new;
                cnt_next = take4_end ? 7'd0 : cnt_inc[6:0];
                if (take4_end) begin
                    if (fa_new > {28'd0, max_digests_reg}) begin
                        stop_next  = STOP_TOO_MANY;
                        phase_next = PH_STOP;
                    end else begin
                        dtotal_next = fa_new[3:0];
                        dleft_next  = fa_new[3:0];
                        seen_next   = 5'd0;
                        phase_next  = (fa_new[3:0] == 4'd0) ? PH_SIZE : PH_ALG;
                    end
                end
            end
            PH_ALG: begin
                res.byte_role = ROLE_ALG;
                fa_next  = fa_new;
                cnt_next = take2_end ? 7'd0 : cnt_inc[6:0];
                if (take2_end) begin
                    if (!hit.valid) begin
                        stop_next  = STOP_BAD_ALG;
                        phase_next = PH_STOP;
                    end else begin
                        bank_next  = hit.bank;
                        seen_next  = seen_reg | (5'd1 << hit.bank);
                        phase_next = PH_DIGEST;
                    end
                end
            end
            PH_DIGEST: begin
                res.byte_role   = ROLE_DIGEST;
                res.digest_bank = bank_reg;
                if (cnt_inc >= {1'b0, bank_size(bank_reg)}) begin
                    cnt_next   = 7'd0;
                    dleft_next = dleft_dec;
                    phase_next = (dleft_dec == 4'd0) ? PH_SIZE : PH_ALG;
                end else begin
                    cnt_next = cnt_inc[6:0];
                end
            end
            PH_SIZE: begin
                res.byte_role = ROLE_SIZE;
                fa_next  = fa_new;
                cnt_next = take4_end ? 7'd0 : cnt_inc[6:0];
                if (take4_end) begin
                    dlen_next = fa_new;
                    if (fa_new == 32'd0) begin
                        done = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                res.byte_role = ROLE_DATA;
                dlen_next = dlen_reg - 32'd1;
                if (dlen_next == 32'd0) begin
                    done = 1'b1;
                end
            end
            default: begin
                res.byte_role = ROLE_IGNORED;
            end
        endcase

        if (done) begin
            if (records_reg != '1) begin
                records_next = records_reg + ENTRY_COUNT_BITS'(1);
            end
            res.entry_done   = 1'b1;
            res.pcr_index    = index_reg;
            res.event_type   = type_reg;
            res.digest_count = dtotal_reg;
            res.bank_mask    = seen_next;
            res.data_length  = fa_next;
            phase_next       = PH_INDEX;
            boundary         = 1'b1;
        end

        if (s_tlast && stop_next == STOP_NONE && !boundary) begin
            stop_next = STOP_TRUNCATED;
        end

        res.stop_status = stop_next;
        res.log_done    = s_tlast;
        res.entry_count = records_next;

        // re-arm after the final byte
        if (s_tlast) begin
            phase_next   = PH_INDEX;
            first_next   = 1'b1;
            cnt_next     = 7'd0;
            fa_next      = 32'd0;
            index_next   = 32'd0;
            type_next    = 32'd0;
            dtotal_next  = 4'd0;
            dleft_next   = 4'd0;
            bank_next    = 3'd0;
            seen_next    = 5'd0;
            dlen_next    = 32'd0;
            stop_next    = STOP_NONE;
            records_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_INDEX;
            first_reg   <= 1'b1;
            cnt_reg     <= 7'd0;
            fa_reg      <= 32'd0;
            index_reg   <= 32'd0;
            type_reg    <= 32'd0;
            dtotal_reg  <= 4'd0;
            dleft_reg   <= 4'd0;
            bank_reg    <= 3'd0;
            seen_reg    <= 5'd0;
            dlen_reg    <= 32'd0;
            stop_reg    <= STOP_NONE;
            records_reg <= '0;
        end else if (push) begin
            phase_reg   <= phase_next;
            first_reg   <= first_next;
            cnt_reg     <= cnt_next;
            fa_reg      <= fa_next;
            index_reg   <= index_next;
            type_reg    <= type_next;
            dtotal_reg  <= dtotal_next;
            dleft_reg   <= dleft_next;
            bank_reg    <= bank_next;
            seen_reg    <= seen_next;
            dlen_reg    <= dlen_next;
            stop_reg    <= stop_next;
            records_reg <= records_next;
        end
    end

    // result buffer: output register plus skid entry
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    assign s_tready = !skid_valid_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = push;
            end else begin
                out_next       = res;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.byte_role;
    assign m_tlast  = out_reg.log_done;
    assign m_tdata  = TDATA_W'({out_reg.entry_count, out_reg.stop_status,
                                out_reg.data_length, out_reg.bank_mask,
                                out_reg.digest_count, out_reg.event_type,
                                out_reg.pcr_index, out_reg.entry_done,
                                out_reg.digest_bank});

endmodule
